// File: hw/rtl/software_timer_table_top_macros.svh
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Immediate-cycle and next-cycle implication checks, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_TOP_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_TOP_MACROS_SVH

`ifndef SYNTH
// ante implies cons in the same cycle
`define STT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer table: same-cycle check failed");
// ante implies cons in the next cycle
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer table: next-cycle check failed");
`else
`define STT_ASSERT_SAME(label, clk, rst, ante, cons)
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, operation and reply codes, and the aging result type.
// ----------------------------------------------------------------------------
package stt_pkg;

   // slot table size; slot numbers are 5 bits wide
   localparam int NSLOT   = 32;
   localparam int SLOT_W  = 5;
   localparam int DELAY_W = 31;
   localparam int TIME_W  = 32;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_SET    = 2'd0;
   localparam opcode_type OP_CHANGE = 2'd1;
   localparam opcode_type OP_DELETE = 2'd2;
   localparam opcode_type OP_UPDATE = 2'd3;

   typedef logic [1:0] kind_type;
   localparam kind_type RK_SET    = 2'd0;
   localparam kind_type RK_CHANGE = 2'd1;
   localparam kind_type RK_EXPIRY = 2'd2;

   // outcome of aging one slot
   typedef struct packed {
      logic              expired;
      logic [TIME_W-1:0] rem_next;
   } age_res_type;

endpackage

// File: hw/rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, read data registered when rd_en is high
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/stt_age.sv
// ----------------------------------------------------------------------------
// Slot aging
// Subtracts elapsed time from one slot, reloads periodic slots, saturates.
// ----------------------------------------------------------------------------
module stt_age (
   input  logic [stt_pkg::TIME_W-1:0]  remaining,
   input  logic [stt_pkg::DELAY_W-1:0] reload,
   input  logic [stt_pkg::TIME_W-1:0]  elapsed,
   input  logic                        one_shot,
   output stt_pkg::age_res_type        result
);
   import stt_pkg::*;

   localparam int AW = TIME_W + 3;

   logic [AW-1:0] diff;
   logic [AW-1:0] reloaded;
   logic [AW-1:0] value;
   logic          below_min;

   // signed remainder minus unsigned elapsed, kept wide
   assign diff = {{3{remaining[TIME_W-1]}}, remaining} - {3'b000, elapsed};

   // periodic slot that went negative gets its interval added back
   assign reloaded = diff + {{(AW-DELAY_W){1'b0}}, reload};
   assign value    = (diff[AW-1] && !one_shot) ? reloaded : diff;

   // only the lower bound can be exceeded
   assign below_min = value[AW-1] && (value[AW-2:TIME_W-1] != '1);

   assign result.expired  = diff[AW-1];
   assign result.rem_next = below_min ? {1'b1, {(TIME_W-1){1'b0}}}
                                      : value[TIME_W-1:0];

endmodule

// File: hw/rtl/software_timer_table_top.sv
// ----------------------------------------------------------------------------
// Software timer table
// Slot table with set, change, delete and time-update commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command item is taken on a rising edge with start high and busy low.
//   Set returns one reply with the lowest free slot (ok 0 when full), change
//   returns one reply (ok 0 for an inactive slot), delete returns nothing.
//   Set, change and delete keep busy low; their reply is registered and
//   is on the rsp_ ports in the cycle after the item is taken.
//   An update holds busy high through the walk, a flush state and a done
//   state: the walk reads one slot per cycle through the single read port
//   of the remaining-time memory, the flush state ages the last slot and the
//   done state releases the final expiry. Expiry items come out in ascending
//   slot order, at most one per cycle; rsp_last marks the command's final item.
//   Each rsp_strobe pulse lasts one cycle and the receiver cannot stall it.
//   Reset frees every slot and clears the stored time to zero; the
//   memories need no clearing since a slot is always written before it
//   becomes active.
// ----------------------------------------------------------------------------
`include "software_timer_table_top_macros.svh"

module software_timer_table_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [stt_pkg::DELAY_W-1:0]  req_delay_ms,
   input  logic                         req_one_shot,
   input  logic [stt_pkg::SLOT_W-1:0]   req_slot_select,
   input  logic [stt_pkg::TIME_W-1:0]   req_now_ms,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_reply_kind,
   output logic [stt_pkg::SLOT_W-1:0]   rsp_slot_id,
   output logic                         rsp_ok,
   output logic                         rsp_last
);
   import stt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [NSLOT-1:0]   active_ff, active_in;
   logic [NSLOT-1:0]   oneshot_ff, oneshot_in;
   logic [TIME_W-1:0]  prev_ff, prev_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic               proc_vld_ff, proc_vld_in;
   logic [SLOT_W-1:0]  proc_slot_ff, proc_slot_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   opcode_type         op;
   logic               free_found;
   logic [SLOT_W-1:0]  free_slot;
   logic               rem_we;
   logic [SLOT_W-1:0]  rem_wa;
   logic [TIME_W-1:0]  rem_wd;
   logic               rel_we;
   logic [SLOT_W-1:0]  rel_wa;
   logic               rd_en;
   logic [TIME_W-1:0]  rem_rd;
   logic [DELAY_W-1:0] rel_rd;
   age_res_type        age;
   logic               expire;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign op     = req_opcode;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NSLOT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   // memory ports: set writes both memories at accept, change writes the reload memory, the walk writes back aged slots
   assign rem_we = (accept && (op == OP_SET) && free_found) || proc_vld_ff;
   assign rem_wa = proc_vld_ff ? proc_slot_ff : free_slot;
   assign rem_wd = proc_vld_ff ? age.rem_next : {1'b0, req_delay_ms};
   assign rel_we = accept && (((op == OP_SET) && free_found) ||
                              ((op == OP_CHANGE) && active_ff[req_slot_select]));
   assign rel_wa = (op == OP_SET) ? free_slot : req_slot_select;
   assign rd_en  = (state_ff == ST_WALK);

   stt_ram #(.WIDTH(TIME_W), .DEPTH(NSLOT)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (rem_wa),
      .wr_data (rem_wd),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rem_rd)
   );

   stt_ram #(.WIDTH(DELAY_W), .DEPTH(NSLOT)) u_rel_ram (
      .clock   (clock),
      .wr_en   (rel_we),
      .wr_addr (rel_wa),
      .wr_data (req_delay_ms),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rel_rd)
   );

   stt_age u_age (
      .remaining (rem_rd),
      .reload    (rel_rd),
      .elapsed   (elapsed_ff),
      .one_shot  (oneshot_ff[proc_slot_ff]),
      .result    (age)
   );

   assign expire = proc_vld_ff && age.expired;

   // sequencer and slot flags
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      oneshot_in   = oneshot_ff;
      prev_in      = prev_ff;
      elapsed_in   = elapsed_ff;
      proc_vld_in  = 1'b0;
      proc_slot_in = proc_slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_SET: begin
                     if (free_found) begin
                        active_in[free_slot]  = 1'b1;
                        oneshot_in[free_slot] = req_one_shot;
                     end
                  end
                  OP_DELETE: begin
                     active_in[req_slot_select] = 1'b0;
                  end
                  OP_UPDATE: begin
                     elapsed_in = req_now_ms - prev_ff;
                     prev_in    = req_now_ms;
                     idx_in     = '0;
                     state_in   = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // issue read of slot idx, age it next cycle
            proc_vld_in  = active_ff[idx_ff];
            proc_slot_in = idx_ff;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == SLOT_W'(NSLOT - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // expired one-shot slot frees itself
      if (expire && oneshot_ff[proc_slot_ff]) begin
         active_in[proc_slot_ff] = 1'b0;
      end
   end

   // replies; an expiry is held in the pending register until the next expiry or the done state so that last can be set
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_last_in   = rsp_last_ff;
      pend_vld_in   = pend_vld_ff;
      pend_slot_in  = pend_slot_ff;
      if (accept && (op == OP_SET)) begin
         rsp_strobe_in = 1'b1;
         rsp_kind_in   = RK_SET;
         rsp_slot_in   = free_found ? free_slot : '0;
         rsp_ok_in     = free_found;
         rsp_last_in   = 1'b1;
      end else if (accept && (op == OP_CHANGE)) begin
         rsp_strobe_in = 1'b1;
         rsp_kind_in   = RK_CHANGE;
         rsp_slot_in   = req_slot_select;
         rsp_ok_in     = active_ff[req_slot_select];
         rsp_last_in   = 1'b1;
      end else if (expire) begin
         if (pend_vld_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = RK_EXPIRY;
            rsp_slot_in   = pend_slot_ff;
            rsp_ok_in     = 1'b1;
            rsp_last_in   = 1'b0;
         end
         pend_vld_in  = 1'b1;
         pend_slot_in = proc_slot_ff;
      end else if ((state_ff == ST_DONE) && pend_vld_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_kind_in   = RK_EXPIRY;
         rsp_slot_in   = pend_slot_ff;
         rsp_ok_in     = 1'b1;
         rsp_last_in   = 1'b1;
         pend_vld_in   = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         active_ff     <= '0;
         oneshot_ff    <= '0;
         prev_ff       <= '0;
         proc_vld_ff   <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         active_ff     <= active_in;
         oneshot_ff    <= oneshot_in;
         prev_ff       <= prev_in;
         proc_vld_ff   <= proc_vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      elapsed_ff   <= elapsed_in;
      proc_slot_ff <= proc_slot_in;
      pend_slot_ff <= pend_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_reply_kind = rsp_kind_ff;
   assign rsp_slot_id    = rsp_slot_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_last       = rsp_last_ff;

   // checks
   `STT_ASSERT_SAME(a_pend_in_walk, clock, reset, pend_vld_ff, busy)
   `STT_ASSERT_NEXT(a_update_walks, clock, reset, accept && (op == OP_UPDATE), state_ff == ST_WALK)
   `STT_ASSERT_SAME(a_last_empties, clock, reset, rsp_strobe_ff && rsp_last_ff, !pend_vld_ff)
   `STT_ASSERT_SAME(a_proc_in_walk, clock, reset, proc_vld_ff, (state_ff == ST_WALK) || (state_ff == ST_FLUSH))

endmodule
